>>> design/min_first_topological_sort_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the min-first topological sort block
// Clocked, reset-qualified property forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef MIN_FIRST_TOPOLOGICAL_SORT_TOP_MACROS_SVH
`define MIN_FIRST_TOPOLOGICAL_SORT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MFTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MFTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mfts_pkg.sv
// ----------------------------------------------------------------------------
// mfts_pkg
// Constants, command codes and helpers of the min-first topological sort.
// ----------------------------------------------------------------------------
package mfts_pkg;

  localparam int unsigned MAX_NODES = 64;
  localparam int unsigned ROW_W     = $clog2(MAX_NODES);
  localparam int unsigned CNT_W     = $clog2(MAX_NODES + 1);
  localparam int unsigned NODE_W    = 7;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SORT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic REG_NODE_COUNT = 1'b0;

  // Nodes in use: zero acts as one, anything above the node limit is clamped.
  function automatic logic [CNT_W-1:0] active_nodes(input logic [NODE_W-1:0] cnt);
    logic [CNT_W-1:0] n;
    if (cnt == '0) begin
      n = CNT_W'(1);
    end else if (32'(cnt) > MAX_NODES) begin
      n = CNT_W'(MAX_NODES);
    end else begin
      n = CNT_W'(cnt);
    end
    return n;
  endfunction

  // Index of the lowest set bit (zero when none is set).
  function automatic logic [ROW_W-1:0] lowest_set(input logic [MAX_NODES-1:0] mask);
    logic [ROW_W-1:0] idx;
    idx = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = ROW_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> design/mfts_ram.sv
// ----------------------------------------------------------------------------
// mfts_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mfts_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/min_first_topological_sort_top.sv
// ----------------------------------------------------------------------------
// min_first_topological_sort_top
// Loads precedence chains into an edge matrix and emits the smallest
// topological order (Kahn's algorithm, lowest ready node first).
// ----------------------------------------------------------------------------
// Usage
//   Command channel: an item is taken at a clock edge with start high and
//   busy low. command 0 loads one chain element, 1 sorts and emits, 2 clears.
//   Result channel: result_valid_o marks one cycle per result; order_node_o,
//   last_of_run_o and acyclic_o are valid only in that cycle. The receiver
//   cannot stall, so every result must be taken when shown.
//   Config: APB write of node_count at address 0, read back at the same place.
// Operation
//   Load with an edge: row read, then row write-back in the edge RAM.
//   Load without an edge, clear and unknown codes finish on acceptance.
//   Sort: a sweep of the edge RAM rows counts predecessors (a read of every
//   row and a final step that takes in the last row's data), a seed step fills
//   the ready set, then each emitted node takes a pick step (pick the lowest
//   ready node and read its row) and a release step (release its successors).
//   Results come one register stage after the release, one per pick and
//   release pair; busy stays high until the last release (or the pick that
//   finds no ready node and gives only the status item).
// Reset
//   Row valid bits clear at once, so the edge matrix reads as empty with no
//   clearing pass; node_count returns to 64.
// ----------------------------------------------------------------------------
`include "min_first_topological_sort_top_macros.svh"

module min_first_topological_sort_top
  import mfts_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // command channel
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         command_i,
  input  logic [NODE_W-1:0]        chain_node_i,
  input  logic                     chain_start_i,
  // result channel
  output logic                     result_valid_o,
  output logic [NODE_W-1:0]        order_node_o,
  output logic                     last_of_run_o,
  output logic                     acyclic_o,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_WR,
    S_COUNT,
    S_SEED,
    S_PICK,
    S_RELEASE
  } state_e;

  state_e                 state_q;
  logic [NODE_W-1:0]      node_count_q;
  logic [NODE_W-1:0]      prev_q;          // last chain element, 0 = none
  logic [MAX_NODES-1:0]   row_valid_q;     // rows never written read as zero
  logic                   rd_row_valid_q;  // valid bit of the row being read
  logic [ROW_W-1:0]       wr_row_q;
  logic [ROW_W-1:0]       col_q;
  logic [CNT_W-1:0]       sweep_q;         // row sweep counter, reaches MAX_NODES
  logic [CNT_W-1:0]       pend_q [MAX_NODES];
  logic [MAX_NODES-1:0]   ready_q;
  logic [ROW_W-1:0]       low_q;           // node being released
  logic [CNT_W-1:0]       emitted_q;

  logic                   res_valid_q;
  logic [NODE_W-1:0]      res_node_q;
  logic                   res_last_q;
  logic                   res_acyc_q;

  // RAM ports
  logic                   ram_we;
  logic                   ram_re;
  logic [ROW_W-1:0]       ram_raddr;
  logic [MAX_NODES-1:0]   ram_wdata;
  logic [MAX_NODES-1:0]   ram_rdata;
  logic [MAX_NODES-1:0]   row_data;

  logic                   accept;
  logic                   node_ok;
  logic                   add_edge;
  logic [CNT_W-1:0]       n_eff;
  logic [MAX_NODES-1:0]   in_use;
  logic [MAX_NODES-1:0]   ready_use;
  logic [ROW_W-1:0]       pick;
  logic [CNT_W-1:0]       pend_rel_d [MAX_NODES];
  logic [MAX_NODES-1:0]   ready_rel_d;
  logic                   rel_last;
  logic [CNT_W-1:0]       emitted_inc;
  logic                   cfg_wr;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign node_ok  = (chain_node_i != '0) && (32'(chain_node_i) <= MAX_NODES);
  assign add_edge = node_ok && !chain_start_i && (prev_q != '0);

  assign n_eff = active_nodes(node_count_q);
  always_comb begin
    for (int w = 0; w < MAX_NODES; w++) begin
      in_use[w] = (32'(w) < 32'(n_eff));
    end
  end

  assign ready_use   = ready_q & in_use;
  assign pick        = lowest_set(ready_use);
  assign row_data    = rd_row_valid_q ? ram_rdata : '0;
  assign emitted_inc = emitted_q + CNT_W'(1);

  // Row read address: edge row on a load, sweep row while counting,
  // chosen node while picking.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = sweep_q[ROW_W-1:0];
    case (state_q)
      S_IDLE: begin
        if (accept && command_i == CMD_LOAD && add_edge) begin
          ram_re    = 1'b1;
          ram_raddr = ROW_W'(prev_q - NODE_W'(1));
        end
      end
      S_COUNT: begin
        ram_re    = (32'(sweep_q) != MAX_NODES);
        ram_raddr = sweep_q[ROW_W-1:0];
      end
      S_PICK: begin
        ram_re    = (ready_use != '0);
        ram_raddr = pick;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  assign ram_we    = (state_q == S_LOAD_WR);
  assign ram_wdata = row_data | (MAX_NODES'(1) << col_q);

  // Release of one node: decrement successor counts, wake nodes that hit zero.
  always_comb begin
    ready_rel_d = ready_q;
    for (int w = 0; w < MAX_NODES; w++) begin
      pend_rel_d[w] = pend_q[w];
      if (row_data[w]) begin
        pend_rel_d[w] = (pend_q[w] != '0) ? pend_q[w] - CNT_W'(1) : '0;
        if (pend_rel_d[w] == '0 && in_use[w]) begin
          ready_rel_d[w] = 1'b1;
        end
      end
    end
  end
  assign rel_last = ((ready_rel_d & in_use) == '0);

  mfts_ram #(
    .WIDTH(MAX_NODES),
    .DEPTH(MAX_NODES)
  ) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_row_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Row valid bit travels with the registered RAM read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_row_valid_q <= 1'b0;
    end else if (ram_re) begin
      rd_row_valid_q <= row_valid_q[ram_raddr];
    end
  end

  // Configuration port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NODE_COUNT) ? APB_DW'(node_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_W'(64);
    end else if (cfg_wr && paddr[2] == REG_NODE_COUNT) begin
      node_count_q <= pwdata[NODE_W-1:0];
    end
  end

  // Main sequencer with registered result outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_q      <= '0;
      row_valid_q <= '0;
      wr_row_q    <= '0;
      col_q       <= '0;
      sweep_q     <= '0;
      pend_q      <= '{default: '0};
      ready_q     <= '0;
      low_q       <= '0;
      emitted_q   <= '0;
      res_valid_q <= 1'b0;
      res_node_q  <= '0;
      res_last_q  <= 1'b0;
      res_acyc_q  <= 1'b0;
    end else begin
      // strobe on every release and on the status-only pick
      res_valid_q <= (state_q == S_RELEASE) || (state_q == S_PICK && ready_use == '0);
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (command_i)
              CMD_LOAD: begin
                if (!node_ok) begin
                  prev_q <= '0;
                end else begin
                  prev_q <= chain_node_i;
                  if (add_edge) begin
                    wr_row_q <= ROW_W'(prev_q - NODE_W'(1));
                    col_q    <= ROW_W'(chain_node_i - NODE_W'(1));
                    state_q  <= S_LOAD_WR;
                  end
                end
              end
              CMD_SORT: begin
                sweep_q <= '0;
                pend_q  <= '{default: '0};
                state_q <= S_COUNT;
              end
              CMD_CLEAR: begin
                row_valid_q <= '0;
                prev_q      <= '0;
                pend_q      <= '{default: '0};
                ready_q     <= '0;
                emitted_q   <= '0;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_LOAD_WR: begin
          row_valid_q[wr_row_q] <= 1'b1;
          state_q               <= S_IDLE;
        end
        S_COUNT: begin
          // data of row sweep_q-1 arrives now
          if (sweep_q != '0) begin
            for (int w = 0; w < MAX_NODES; w++) begin
              pend_q[w] <= pend_q[w] + CNT_W'(row_data[w]);
            end
          end
          if (32'(sweep_q) == MAX_NODES) begin
            state_q <= S_SEED;
          end else begin
            sweep_q <= sweep_q + CNT_W'(1);
          end
        end
        S_SEED: begin
          for (int w = 0; w < MAX_NODES; w++) begin
            ready_q[w] <= in_use[w] && (pend_q[w] == '0);
          end
          emitted_q <= '0;
          state_q   <= S_PICK;
        end
        S_PICK: begin
          if (ready_use == '0) begin
            // nothing could be emitted: status item only
            res_node_q  <= '0;
            res_last_q  <= 1'b1;
            res_acyc_q  <= 1'b0;
            state_q     <= S_IDLE;
          end else begin
            ready_q[pick] <= 1'b0;
            low_q         <= pick;
            state_q       <= S_RELEASE;
          end
        end
        S_RELEASE: begin
          pend_q      <= pend_rel_d;
          ready_q     <= ready_rel_d;
          emitted_q   <= emitted_inc;
          res_node_q  <= NODE_W'(low_q) + NODE_W'(1);
          res_last_q  <= rel_last;
          res_acyc_q  <= rel_last && (emitted_inc == n_eff);
          state_q     <= rel_last ? S_IDLE : S_PICK;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign order_node_o   = res_node_q;
  assign last_of_run_o  = res_last_q;
  assign acyclic_o      = res_acyc_q;

  `MFTS_ASSERT_NOW(a_res_from_run, result_valid_o, $past(busy), "result outside a sort run")
  `MFTS_ASSERT_NOW(a_acyc_on_last, result_valid_o && acyclic_o, last_of_run_o, "acyclic off last")
  `MFTS_ASSERT_NOW(a_status_item, result_valid_o && order_node_o == '0,
                   last_of_run_o && !acyclic_o, "status item malformed")
  `MFTS_ASSERT_NEXT(a_sort_busy, accept && command_i == CMD_SORT, busy, "sort did not start")
  `MFTS_ASSERT_NOW(a_write_in_load, ram_we, !ram_re && state_q == S_LOAD_WR,
                   "edge RAM write outside load")

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: min-first topological sort
// Drives chain loads, sorts, clears and ignored codes into the command port
// and rewrites node_count over the APB port between phases. A scoreboard
// keeps its own copy of the edge matrix, predicts each sort run and checks
// every result strobe, field by field, in order.
// ----------------------------------------------------------------------------
module testbench
  import mfts_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Target count of random items; ignored codes do not count toward it.
  localparam int unsigned ITEM_TARGET = 400;
  // Code 3 is not decoded by the block: no state change, no result.
  localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
  localparam logic [APB_AW-1:0] NODE_COUNT_ADDR = APB_AW'(4 * REG_NODE_COUNT);

  // One result strobe as the block shows it.
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              last;
    logic              acyc;
  } order_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow graph, sort predictor and the queue of expected results.
  // --------------------------------------------------------------------------
  class topo_order_board;
    logic [MAX_NODES-1:0] succ_rows [MAX_NODES];   // row v-1, bit w-1: edge v->w
    int unsigned          chain_prev;              // 0 = no previous element
    logic [NODE_W-1:0]    node_count;
    order_result_t        expected_order [$];
    int unsigned          errors;

    function new();
      reset_graph();
      node_count = NODE_W'(MAX_NODES);
      errors = 0;
    endfunction

    function void reset_graph();
      foreach (succ_rows[v]) succ_rows[v] = '0;
      chain_prev = 0;
    endfunction

    function int unsigned pending();
      return expected_order.size();
    endfunction

    task report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    // Accepted command item: update the shadow graph or predict a sort run.
    function void note_item(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] node,
                            input logic cs);
      int unsigned          preds [MAX_NODES];
      logic [MAX_NODES-1:0] ready;
      order_result_t        run [$];
      order_result_t        res;
      int unsigned          n;
      int unsigned          low;
      case (cmd)
        CMD_LOAD: begin
          if (node < 1 || node > MAX_NODES) begin
            chain_prev = 0;   // out-of-range element breaks the chain
          end else begin
            if (!cs && chain_prev != 0) succ_rows[chain_prev-1][node-1] = 1'b1;
            chain_prev = node;
          end
        end
        CMD_SORT: begin
          n = (node_count == 0) ? 1 : ((node_count > MAX_NODES) ? MAX_NODES : node_count);
          foreach (preds[w]) begin
            preds[w] = 0;
            for (int v = 0; v < MAX_NODES; v++) preds[w] += succ_rows[v][w];
          end
          ready = '0;
          for (int w = 0; w < n; w++) if (preds[w] == 0) ready[w] = 1'b1;
          while (ready != '0) begin
            low = 0;
            while (!ready[low]) low++;
            ready[low] = 1'b0;
            res.node = NODE_W'(low + 1);
            res.last = 1'b0;
            res.acyc = 1'b0;
            run = {run, res};
            for (int w = 0; w < MAX_NODES; w++) begin
              if (succ_rows[low][w]) begin
                if (preds[w] > 0) preds[w]--;
                if (preds[w] == 0 && w < n) ready[w] = 1'b1;
              end
            end
          end
          if (run.size() == 0) begin
            res.node = '0;     // status only: nothing could be emitted
            res.last = 1'b1;
            res.acyc = 1'b0;
            run = {run, res};
          end else begin
            run[run.size()-1].last = 1'b1;
            run[run.size()-1].acyc = (run.size() == n);
          end
          foreach (run[i]) expected_order = {expected_order, run[i]};
        end
        CMD_CLEAR: begin
          reset_graph();
        end
        default: begin
        end
      endcase
    endfunction

    task check_result(input logic [NODE_W-1:0] node, input logic last, input logic acyc);
      order_result_t want;
      if (expected_order.size() == 0) begin
        report_mismatch($sformatf("unexpected result node=%0d last=%0b acyclic=%0b",
                                  node, last, acyc));
        return;
      end
      want = expected_order.pop_front();
      if (node !== want.node)
        report_mismatch($sformatf("order_node %0d, expected %0d", node, want.node));
      if (last !== want.last)
        report_mismatch($sformatf("last_of_run %0b, expected %0b (node %0d)",
                                  last, want.last, want.node));
      if (acyc !== want.acyc)
        report_mismatch($sformatf("acyclic %0b, expected %0b (node %0d)",
                                  acyc, want.acyc, want.node));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  command_i;
  logic [NODE_W-1:0] chain_node_i;
  logic              chain_start_i;
  logic              result_valid_o;
  logic [NODE_W-1:0] order_node_o;
  logic              last_of_run_o;
  logic              acyclic_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  topo_order_board board = new();
  int unsigned     items_sent;
  bit              gaps_on;

  min_first_topological_sort_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .chain_node_i   (chain_node_i),
    .chain_start_i  (chain_start_i),
    .result_valid_o (result_valid_o),
    .order_node_o   (order_node_o),
    .last_of_run_o  (last_of_run_o),
    .acyclic_o      (acyclic_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // 10 ns clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results cannot be held off: every strobe is checked at the edge ending it.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) board.check_result(order_node_o, last_of_run_o, acyclic_o);
  end

  // --------------------------------------------------------------------------
  // Drivers. Inputs move at the falling edge; handshakes are read at the
  // rising edge, before the block's own updates of that edge land.
  // --------------------------------------------------------------------------

  // One command item. start stays high on return, so back-to-back items do
  // not drop it; an optional burst of idle cycles comes first.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] node,
                           input logic cs);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        start = 1'b0;
        @(posedge clk_i);
      end
    end
    @(negedge clk_i);
    start         = 1'b1;
    command_i     = cmd;
    chain_node_i  = node;
    chain_start_i = cs;
    do @(posedge clk_i); while (busy);
    board.note_item(cmd, node, cs);
    if (cmd != CMD_IGNORED) items_sent++;
  endtask

  // Non-load command; the unused fields carry random junk.
  task automatic issue(input logic [CMD_W-1:0] cmd);
    send_item(cmd, NODE_W'($urandom), 1'($urandom));
  endtask

  // Hold off until every expected result is in and the block is idle. A load
  // gives no result, so leave room for its row write-back first.
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // APB write of node_count, then a read back of the same register.
  task automatic config_node_count(input logic [NODE_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = NODE_COUNT_ADDR;
    pwdata  = APB_DW'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    board.node_count = value;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    pwdata  = '0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[NODE_W-1:0] !== value)
      board.report_mismatch($sformatf("node_count read %0d, expected %0d",
                                      prdata[NODE_W-1:0], value));
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned       perm [MAX_NODES];
    int unsigned       n_eff;
    int unsigned       phase_kind;
    int unsigned       chains;
    int unsigned       len;
    int unsigned       idx;
    int unsigned       j;
    int unsigned       k;
    int unsigned       tmp;
    int unsigned       r;
    logic [NODE_W-1:0] cnt_val;

    rst_ni        = 1'b0;
    start         = 1'b0;
    command_i     = CMD_LOAD;
    chain_node_i  = '0;
    chain_start_i = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    items_sent    = 0;
    gaps_on       = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // ---- directed part ----
    // Empty graph at the reset count of 64: full ascending order, acyclic.
    issue(CMD_SORT);
    // Chain 3->1->64; then an element of 0 breaks the chain, so the next 5
    // adds nothing, and a second 5 adds a self edge (5 never ready).
    send_item(CMD_LOAD, 7'd3, 1'b1);
    send_item(CMD_LOAD, 7'd1, 1'b0);
    send_item(CMD_LOAD, 7'd64, 1'b0);
    send_item(CMD_LOAD, 7'd0, 1'b0);
    send_item(CMD_LOAD, 7'd5, 1'b0);
    send_item(CMD_LOAD, 7'd5, 1'b0);
    // Nodes beyond the node limit break the chain too, with or without start.
    send_item(CMD_LOAD, 7'd100, 1'b0);
    send_item(CMD_LOAD, 7'd127, 1'b1);
    issue(CMD_IGNORED);
    // A chain start with a previous element pending adds no edge; 6->4 does.
    send_item(CMD_LOAD, 7'd2, 1'b1);
    send_item(CMD_LOAD, 7'd6, 1'b1);
    send_item(CMD_LOAD, 7'd4, 1'b0);
    // Self edge makes the run cyclic; sorting twice must repeat the order.
    issue(CMD_SORT);
    issue(CMD_SORT);
    // Count 0 acts as 1; node 1 waits on 3, so only the status item comes.
    drain();
    config_node_count(7'd0);
    issue(CMD_SORT);
    // Count above the node limit acts as 64; cleared graph sorts in order.
    drain();
    config_node_count(7'd127);
    issue(CMD_CLEAR);
    issue(CMD_SORT);
    // Edge from a node above node_count: 6 is never emitted, so 2 never
    // becomes ready and the run ends 1,3,4 without the acyclic flag.
    drain();
    config_node_count(7'd4);
    send_item(CMD_LOAD, 7'd6, 1'b1);
    send_item(CMD_LOAD, 7'd2, 1'b0);
    issue(CMD_SORT);
    // Smallest legal count.
    drain();
    config_node_count(7'd1);
    issue(CMD_SORT);
    drain();
    config_node_count(7'd64);
    issue(CMD_SORT);

    // ---- random part ----
    // Each phase: drain, new count, usually a clear, a few chains, a sort (sometimes two).
    // Most phases load chains that follow a random permutation, so the
    // new edges close no cycle and the sort walks deep; the rest are random chains
    // (cycles, nodes above the count) or noise.
    items_sent = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      // Last stretch of the run goes without idle cycles.
      gaps_on = (items_sent < ITEM_TARGET * 85 / 100) && ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 9);
      if (r < 7) cnt_val = NODE_W'($urandom_range(1, 16));
      else if (r < 9) cnt_val = NODE_W'($urandom_range(17, 64));
      else cnt_val = NODE_W'($urandom_range(0, 127));
      config_node_count(cnt_val);
      n_eff = (cnt_val == 0) ? 1 : ((cnt_val > MAX_NODES) ? MAX_NODES : cnt_val);
      if ($urandom_range(0, 3) != 0) issue(CMD_CLEAR);

      for (j = 0; j < n_eff; j++) perm[j] = j + 1;
      for (j = n_eff - 1; j > 0; j--) begin
        k       = $urandom_range(0, j);
        tmp     = perm[j];
        perm[j] = perm[k];
        perm[k] = tmp;
      end

      phase_kind = $urandom_range(0, 9);
      chains     = $urandom_range(1, 4);
      repeat (chains) begin
        len = $urandom_range(2, 6);
        idx = $urandom_range(0, n_eff - 1);
        for (j = 0; j < len; j++) begin
          if (phase_kind < 6) begin
            // increasing positions in the permutation: these edges close no cycle
            if (idx >= n_eff) break;
            send_item(CMD_LOAD, NODE_W'(perm[idx]), j == 0);
            idx += $urandom_range(1, 3);
          end else if (phase_kind < 8) begin
            // free chain, sometimes one node past the count
            send_item(CMD_LOAD,
                      NODE_W'($urandom_range(1, (n_eff < MAX_NODES) ? n_eff + 1 : MAX_NODES)),
                      j == 0);
          end else begin
            case ($urandom_range(0, 4))
              0: begin
                issue(CMD_IGNORED);
              end
              1: begin
                send_item(CMD_LOAD, NODE_W'($urandom_range(0, 127)), 1'($urandom));
              end
              2: begin
                issue(CMD_SORT);
              end
              default: begin
                send_item(CMD_LOAD, NODE_W'($urandom_range(1, n_eff)), 1'($urandom));
              end
            endcase
          end
        end
      end
      issue(CMD_SORT);
      if ($urandom_range(0, 4) == 0) issue(CMD_SORT);
    end

    // ---- wind down ----
    @(negedge clk_i);
    start = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    // Watch for stray strobes after the last expected result.
    repeat (200) @(posedge clk_i);
    if (board.pending() != 0)
      board.report_mismatch($sformatf("%0d expected results never came", board.pending()));
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run (every item a 64-node sort
  // with the longest idle burst in front of it).
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
